[sv/sps_pkg.sv]
package sps_pkg;

    localparam int MAX_ELEMENTS_DEF = 4096;

    localparam int VALUE_W = 31;
    localparam int SUM_W   = 32;
    localparam int COUNT_W = 30;

    localparam logic [COUNT_W-1:0] PAIR_MOD = 30'd1000000007;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_LOOP,
        ST_EVAL,
        ST_LREQ,
        ST_LCHK,
        ST_RREQ,
        ST_RCHK,
        ST_ACC,
        ST_WAIT,
        ST_DONE
    } walk_state_t;

    typedef enum logic [1:0] {
        ACC_IDLE,
        ACC_ADD,
        ACC_RED
    } acc_phase_t;

    typedef struct packed {
        logic start;
        logic half;
    } acc_req_t;

    typedef struct packed {
        logic done;
    } acc_rsp_t;

endpackage

[sv/sps_if.sv]
interface sps_in_if
    import sps_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] element_value;
    logic               last_element;

    modport source (output valid, output element_value, output last_element, input ready);
    modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

interface sps_out_if
    import sps_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] pair_count;
    logic               overflow_flag;

    modport source (output valid, output pair_count, output overflow_flag, input ready);
    modport sink   (input valid, input pair_count, input overflow_flag, output ready);
endinterface

[sv/sps_store.sv]
module sps_store
    import sps_pkg::*;
#(
    parameter int DEPTH = MAX_ELEMENTS_DEF,
    parameter int AW    = $clog2(DEPTH)
)(
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [VALUE_W-1:0] wdata,
    input  logic               re_a,
    input  logic [AW-1:0]      raddr_a,
    output logic [VALUE_W-1:0] rdata_a,
    input  logic               re_b,
    input  logic [AW-1:0]      raddr_b,
    output logic [VALUE_W-1:0] rdata_b
);

    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

[sv/sps_mod_acc.sv]
module sps_mod_acc
    import sps_pkg::*;
#(
    parameter int CW = 13
)(
    input  logic               clk,
    input  logic               rst_n,
    input  acc_req_t           req,
    input  logic [CW-1:0]      op_a,
    input  logic [CW-1:0]      op_b,
    input  logic [COUNT_W-1:0] count_in,
    output acc_rsp_t           rsp,
    output logic [COUNT_W-1:0] sum_out
);

    localparam int PW = 2 * CW;
    localparam int SW = ((PW > COUNT_W) ? PW : COUNT_W) + 1;

    acc_phase_t     phase_reg, phase_next;
    logic [PW-1:0]  prod_reg;
    logic           half_reg;
    logic [SW-1:0]  acc_reg, acc_next;
    logic [SW-1:0]  term;
    logic           below_mod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ACC_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == ACC_IDLE && req.start)
        begin
            prod_reg <= op_a * op_b;
            half_reg <= req.half;
        end
        acc_reg <= acc_next;
    end

    assign term      = half_reg ? SW'(prod_reg >> 1) : SW'(prod_reg);
    assign below_mod = acc_reg < SW'(PAIR_MOD);
    assign sum_out   = acc_reg[COUNT_W-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        rsp.done   = 1'b0;
        case (phase_reg)
            ACC_IDLE:
            begin
                if (req.start)
                begin
                    phase_next = ACC_ADD;
                end
            end
            ACC_ADD:
            begin
                acc_next   = SW'(count_in) + term;
                phase_next = ACC_RED;
            end
            ACC_RED:
            begin
                if (below_mod)
                begin
                    rsp.done   = 1'b1;
                    phase_next = ACC_IDLE;
                end
                else
                begin
                    acc_next = acc_reg - SW'(PAIR_MOD);
                end
            end
            default:
            begin
                phase_next = ACC_IDLE;
            end
        endcase
    end

endmodule

[sv/sorted_pair_sum_counter.sv]
// channel   role    payload                          handshake
// in_ch     sink    element_value, last_element      valid/ready
// out_ch    source  pair_count, overflow_flag        valid/ready
// cfg       write   cfg_wdata (target_sum)           cfg_we, no wait
//
// loading accepts one word per cycle; after the last word the walk runs with in_ch.ready low
// each pointer step is one store read pair (ST_LOOP) followed by one compare (ST_EVAL)
// a matched run reads each run element in a request state and a check state, then the
// accumulator multiplies the run lengths, adds and reduces mod PAIR_MOD
// the store read in the walk loop is registered; no clearing pass
// rst_n clears control state at once; the store itself is not cleared
// a result held in out_ch does not stop loading of the next list
module sorted_pair_sum_counter
    import sps_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [SUM_W-1:0] cfg_wdata,
    sps_in_if.sink        in_ch,
    sps_out_if.source     out_ch
);

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    walk_state_t          state_reg, state_next;
    logic [SUM_W-1:0]     target_reg;
    logic [CW-1:0]        total_reg, total_next;
    logic                 dropped_reg, dropped_next;
    logic signed [CW:0]   lo_reg, lo_next;
    logic signed [CW:0]   hi_reg, hi_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [VALUE_W-1:0]   a_reg, a_next;
    logic [VALUE_W-1:0]   b_reg, b_next;
    logic [CW-1:0]        run_l_reg, run_l_next;
    logic [CW-1:0]        run_r_reg, run_r_next;
    logic                 half_reg, half_next;
    logic                 brk_reg, brk_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic                 mem_we;
    logic                 re_a, re_b;
    logic [VALUE_W-1:0]   rdata_a, rdata_b;
    logic [SUM_W-1:0]     pair_sum;
    logic [CW-1:0]        diff;
    logic                 in_acc;
    acc_req_t             acc_req;
    acc_rsp_t             acc_rsp;
    logic [COUNT_W-1:0]   acc_sum;

    sps_store #(
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (total_reg[AW-1:0]),
        .wdata   (in_ch.element_value),
        .re_a    (re_a),
        .raddr_a (lo_reg[AW-1:0]),
        .rdata_a (rdata_a),
        .re_b    (re_b),
        .raddr_b (hi_reg[AW-1:0]),
        .rdata_b (rdata_b)
    );

    sps_mod_acc #(
        .CW (CW)
    ) u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (acc_req),
        .op_a     (run_l_reg),
        .op_b     (run_r_reg),
        .count_in (count_reg),
        .rsp      (acc_rsp),
        .sum_out  (acc_sum)
    );

    assign in_ch.ready          = (state_reg == ST_LOAD);
    assign in_acc               = in_ch.valid && in_ch.ready;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.pair_count    = out_count_reg;
    assign out_ch.overflow_flag = out_ovf_reg;

    assign pair_sum = {1'b0, rdata_a} + {1'b0, rdata_b};
    assign diff     = hi_reg[CW-1:0] - lo_reg[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            target_reg    <= '0;
            total_reg     <= '0;
            dropped_reg   <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end
            total_reg     <= total_next;
            dropped_reg   <= dropped_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        run_l_reg     <= run_l_next;
        run_r_reg     <= run_r_next;
        half_reg      <= half_next;
        brk_reg       <= brk_next;
        out_count_reg <= out_count_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        dropped_next   = dropped_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        count_next     = count_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        run_l_next     = run_l_reg;
        run_r_next     = run_r_reg;
        half_next      = half_reg;
        brk_next       = brk_reg;
        out_count_next = out_count_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        mem_we         = 1'b0;
        re_a           = 1'b0;
        re_b           = 1'b0;
        acc_req.start  = 1'b0;
        acc_req.half   = half_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (total_reg < CW'(MAX_ELEMENTS))
                    begin
                        mem_we     = 1'b1;
                        total_next = total_reg + {{(CW-1){1'b0}}, 1'b1};
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (in_ch.last_element)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                lo_next    = '0;
                hi_next    = {1'b0, total_reg} - {{CW{1'b0}}, 1'b1};
                count_next = '0;
                state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (lo_reg < hi_reg)
                begin
                    re_a       = 1'b1;
                    re_b       = 1'b1;
                    state_next = ST_EVAL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_EVAL:
            begin
                if (pair_sum == target_reg)
                begin
                    if (rdata_a == rdata_b)
                    begin
                        // remaining run pairs among themselves
                        run_l_next = diff + {{(CW-1){1'b0}}, 1'b1};
                        run_r_next = diff;
                        half_next  = 1'b1;
                        brk_next   = 1'b1;
                        state_next = ST_ACC;
                    end
                    else
                    begin
                        a_next     = rdata_a;
                        b_next     = rdata_b;
                        run_l_next = '0;
                        run_r_next = '0;
                        half_next  = 1'b0;
                        brk_next   = 1'b0;
                        state_next = ST_LREQ;
                    end
                end
                else if (pair_sum > target_reg)
                begin
                    hi_next    = hi_reg - {{CW{1'b0}}, 1'b1};
                    state_next = ST_LOOP;
                end
                else
                begin
                    lo_next    = lo_reg + {{CW{1'b0}}, 1'b1};
                    state_next = ST_LOOP;
                end
            end
            ST_LREQ:
            begin
                if (lo_reg <= hi_reg)
                begin
                    re_a       = 1'b1;
                    state_next = ST_LCHK;
                end
                else
                begin
                    state_next = ST_RREQ;
                end
            end
            ST_LCHK:
            begin
                if (rdata_a == a_reg)
                begin
                    run_l_next = run_l_reg + {{(CW-1){1'b0}}, 1'b1};
                    lo_next    = lo_reg + {{CW{1'b0}}, 1'b1};
                    state_next = ST_LREQ;
                end
                else
                begin
                    state_next = ST_RREQ;
                end
            end
            ST_RREQ:
            begin
                if (hi_reg >= lo_reg)
                begin
                    re_b       = 1'b1;
                    state_next = ST_RCHK;
                end
                else
                begin
                    state_next = ST_ACC;
                end
            end
            ST_RCHK:
            begin
                if (rdata_b == b_reg)
                begin
                    run_r_next = run_r_reg + {{(CW-1){1'b0}}, 1'b1};
                    hi_next    = hi_reg - {{CW{1'b0}}, 1'b1};
                    state_next = ST_RREQ;
                end
                else
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                acc_req.start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (acc_rsp.done)
                begin
                    count_next = acc_sum;
                    state_next = brk_reg ? ST_DONE : ST_LOOP;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_ovf_next   = dropped_reg;
                    total_next     = '0;
                    dropped_next   = 1'b0;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

[sv/sps_checker.sv]
module sps_checker
    import sps_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               in_last,
    input logic               out_valid,
    input logic               out_ready,
    input logic [COUNT_W-1:0] out_count,
    input logic               out_ovf
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_count) && $stable(out_ovf))
        else $error("result word changed while stalled");

    // last word starts the walk, input closes
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input still open after last word");

    // a fresh result only comes out of the walk
    a_rise_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a walk");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_count < PAIR_MOD)
        else $error("pair count not reduced");

endmodule

bind sorted_pair_sum_counter sps_checker u_sps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.last_element),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_count (out_ch.pair_count),
    .out_ovf   (out_ch.overflow_flag)
);

[verif/testbench.sv]
module testbench;
    import sps_pkg::*;

    localparam int DEPTH = MAX_ELEMENTS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [VALUE_W-1:0] VALUE_TOP = '1;
    localparam longint VALUE_TOP_L = longint'(VALUE_TOP);
    localparam longint MOD_L = longint'(PAIR_MOD);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } input_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } pair_result_t;

    typedef logic [VALUE_W-1:0] value_q_t[$];

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [SUM_W-1:0] cfg_wdata;

    sps_in_if  in_ch();
    sps_out_if out_ch();

    sorted_pair_sum_counter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #1 clk = ~clk;

    input_word_t  word_fifo[$];
    pair_result_t pending_counts[$];
    int unsigned  words_queued = 0;
    int unsigned  words_accepted = 0;
    int unsigned  mismatches = 0;
    int unsigned  cycle_count = 0;
    int           in_gap_pct = 8;
    int           out_stall_pct = 66;

    // predictor state
    logic [SUM_W-1:0]   target = '0;
    logic [VALUE_W-1:0] list_vals [DEPTH];
    int                 list_len = 0;
    logic               list_dropped = 1'b0;

    function automatic logic [COUNT_W-1:0] count_matching_pairs();
        int lo;
        int hi;
        longint acc;
        longint a;
        longint b;
        longint x;
        longint run_lo;
        longint run_hi;
        lo = 0;
        hi = list_len - 1;
        acc = 0;
        while (lo < hi) begin
            a = longint'(list_vals[lo]);
            b = longint'(list_vals[hi]);
            if (a + b == longint'(target)) begin
                if (a == b) begin
                    x = hi - lo + 1;
                    acc = (acc + (x * (x - 1) / 2) % MOD_L) % MOD_L;
                    break;
                end
                run_lo = 0;
                run_hi = 0;
                while (lo <= hi && longint'(list_vals[lo]) == a) begin
                    run_lo++;
                    lo++;
                end
                while (hi >= lo && longint'(list_vals[hi]) == b) begin
                    run_hi++;
                    hi--;
                end
                acc = (acc + (run_lo * run_hi) % MOD_L) % MOD_L;
            end
            else if (a + b > longint'(target))
                hi--;
            else
                lo++;
        end
        return acc[COUNT_W-1:0];
    endfunction

    function automatic void take_word(logic [VALUE_W-1:0] v, logic last);
        pair_result_t r;
        if (list_len < DEPTH) begin
            list_vals[list_len] = v;
            list_len++;
        end
        else
            list_dropped = 1'b1;
        if (last) begin
            r.count = count_matching_pairs();
            r.overflow = list_dropped;
            pending_counts.push_back(r);
            list_len = 0;
            list_dropped = 1'b0;
        end
    endfunction

    // driver
    always @(posedge clk) begin : driver
        input_word_t w;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_ch.ready) begin
            if (word_fifo.size() != 0 && $urandom_range(99) >= in_gap_pct) begin
                w = word_fifo.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.element_value <= w.value;
                in_ch.last_element <= w.last;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk) begin : monitor
        pair_result_t exp_r;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else begin
            if (in_ch.valid && in_ch.ready) begin
                take_word(in_ch.element_value, in_ch.last_element);
                words_accepted++;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (pending_counts.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, actual count %0d flag %0b",
                             $time, out_ch.pair_count, out_ch.overflow_flag);
                end
                else begin
                    exp_r = pending_counts.pop_front();
                    if (out_ch.pair_count !== exp_r.count) begin
                        mismatches++;
                        $display("%0t: pair_count expected %0d actual %0d",
                                 $time, exp_r.count, out_ch.pair_count);
                    end
                    if (out_ch.overflow_flag !== exp_r.overflow) begin
                        mismatches++;
                        $display("%0t: overflow_flag expected %0b actual %0b",
                                 $time, exp_r.overflow, out_ch.overflow_flag);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic queue_words(input value_q_t vals);
        input_word_t w;
        foreach (vals[i]) begin
            w.value = vals[i];
            w.last = (i == vals.size() - 1);
            word_fifo.push_back(w);
            words_queued++;
        end
    endtask

    // list with random content, sorted when keep_sorted is set, biased toward pairs that hit the target
    task automatic queue_list(input int n, input bit keep_sorted);
        value_q_t vals;
        logic [VALUE_W-1:0] anchors [6];
        longint lo_a;
        longint hi_a;
        longint a;
        longint b;
        lo_a = (longint'(target) > VALUE_TOP_L) ? longint'(target) - VALUE_TOP_L : 0;
        hi_a = (longint'(target) < VALUE_TOP_L) ? longint'(target) : VALUE_TOP_L;
        for (int k = 0; k < 3; k++) begin
            if (lo_a > hi_a) begin
                a = longint'($urandom) & VALUE_TOP_L;
                b = longint'($urandom) & VALUE_TOP_L;
            end
            else begin
                if (k == 0 && $urandom_range(2) == 0)
                    a = longint'(target) / 2;
                else
                    a = lo_a + (longint'($urandom) % (hi_a - lo_a + 1));
                b = longint'(target) - a;
            end
            anchors[2*k] = a[VALUE_W-1:0];
            anchors[2*k+1] = b[VALUE_W-1:0];
        end
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: vals.push_back(VALUE_W'($urandom));
                1, 2: vals.push_back(anchors[$urandom_range(5)] + VALUE_W'($urandom_range(3)));
                default: vals.push_back(anchors[$urandom_range(5)]);
            endcase
        end
        if (keep_sorted)
            vals.sort();
        queue_words(vals);
    endtask

    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (words_accepted != words_queued || pending_counts.size() != 0);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_target(input logic [SUM_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        target = v;
        @(negedge clk);
    endtask

    initial begin
        logic [SUM_W-1:0] target_plan [6];
        int budget;
        int n;
        bit held;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.element_value = '0;
        in_ch.last_element = 1'b0;
        out_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed lists
        write_target(32'd10);
        queue_words('{31'd5});
        queue_words('{31'd1, 31'd2, 31'd5, 31'd5, 31'd5, 31'd8, 31'd9});
        queue_words('{31'd0, 31'd0, 31'd10, 31'd10, 31'd10});
        queue_words('{31'd9, 31'd1, 31'd5, 31'd4});
        wait_for_drain();
        write_target(32'hFFFF_FFFE);
        queue_words('{31'd0, VALUE_TOP, VALUE_TOP, VALUE_TOP});
        wait_for_drain();
        write_target(32'd0);
        queue_words('{31'd0, 31'd0, 31'd0});
        wait_for_drain();
        write_target(32'hFFFF_FFFF);
        queue_words('{VALUE_TOP, VALUE_TOP});
        wait_for_drain();

        target_plan[0] = $urandom;
        target_plan[1] = 32'hFFFF_FFFE;
        target_plan[2] = $urandom_range(2000);
        target_plan[3] = 32'h7FFF_FFFF;
        target_plan[4] = $urandom;
        target_plan[5] = 32'd1;

        for (int regime = 0; regime < 3; regime++) begin
            in_gap_pct = (regime == 0) ? 8 : (regime == 1) ? 66 : 0;
            out_stall_pct = (regime == 0) ? 66 : (regime == 1) ? 8 : 0;
            for (int sub = 0; sub < 2; sub++) begin
                write_target(target_plan[2*regime+sub]);
                budget = 0;
                held = 1'b0;
                while (budget < 160) begin
                    if (!held && budget >= 80) begin
                        wait_for_drain();
                        held = 1'b1;
                    end
                    n = ($urandom_range(19) == 0) ? $urandom_range(120, 25) : $urandom_range(16, 1);
                    queue_list(n, $urandom_range(9) != 0);
                    budget += n;
                end
                wait_for_drain();
            end
        end

        repeat (50) @(negedge clk);

        if (mismatches == 0 && pending_counts.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
